/* hdl/ttc_pkg.sv */
`default_nettype none
package ttc_pkg;

  // clip values are signed Q26.24 in this many bits
  localparam int CLIP_W = 50;
  // quotient magnitude bits kept: 18 integer, 16 fraction
  localparam int QUO_W = 34;
  // numerator bits below the initial partial remainder
  localparam int LO_W = 18;
  // divider depth: one setup stage, then one bit per stage
  localparam int DIV_STAGES = QUO_W + 1;

  localparam logic [2:0] REG_ROW0   = 3'd0;
  localparam logic [2:0] REG_ROW1   = 3'd1;
  localparam logic [2:0] REG_ROW2   = 3'd2;
  localparam logic [2:0] REG_ROW3   = 3'd3;
  localparam logic [2:0] REG_WIDTH  = 3'd4;
  localparam logic [2:0] REG_HEIGHT = 3'd5;

  localparam logic [63:0] ROW0_RESET = 64'h0000_0000_0000_0100;
  localparam logic [63:0] ROW1_RESET = 64'h0000_0000_0100_0000;
  localparam logic [63:0] ROW2_RESET = 64'h0000_0100_0000_0000;
  localparam logic [63:0] ROW3_RESET = 64'h0100_0000_0000_0000;
  localparam logic [12:0] WIDTH_RESET  = 13'd640;
  localparam logic [12:0] HEIGHT_RESET = 13'd480;

endpackage
`default_nettype wire

/* hdl/ttc_div.sv */
`default_nettype none
module ttc_div (
  input  wire logic                          clk,
  input  wire logic                          en,
  input  wire logic [ttc_pkg::CLIP_W-1:0]    num,
  input  wire logic [ttc_pkg::CLIP_W-1:0]    den,
  input  wire logic                          neg_in,
  output logic      [ttc_pkg::QUO_W-1:0]     mag,
  output logic                               ovf,
  output logic                               neg_out
);

  localparam int W  = ttc_pkg::CLIP_W;
  localparam int QW = ttc_pkg::QUO_W;
  localparam int LW = ttc_pkg::LO_W;

  logic [W-1:0]  r    [0:QW];
  logic [W-1:0]  d    [0:QW];
  logic [LW-1:0] lo   [0:QW];
  logic [QW-1:0] q    [0:QW];
  logic          ov   [0:QW];
  logic          ng   [0:QW];

  // setup: quotient overflows when num >= den * 2^18
  always_ff @(posedge clk) begin
    if (en) begin
      r[0]  <= {{LW{1'b0}}, num[W-1:LW]};
      d[0]  <= den;
      lo[0] <= num[LW-1:0];
      q[0]  <= '0;
      ov[0] <= ({{LW{1'b0}}, num} >= {den, {LW{1'b0}}});
      ng[0] <= neg_in;
    end
  end

  for (genvar s = 1; s <= QW; s++) begin : g_step
    logic [W:0] t;
    logic [W:0] diff;
    logic       ge;
    assign t    = {r[s-1], lo[s-1][LW-1]};
    assign diff = t - {1'b0, d[s-1]};
    assign ge   = (t >= {1'b0, d[s-1]});
    always_ff @(posedge clk) begin
      if (en) begin
        r[s]  <= ge ? diff[W-1:0] : t[W-1:0];
        d[s]  <= d[s-1];
        lo[s] <= {lo[s-1][LW-2:0], 1'b0};
        q[s]  <= {q[s-1][QW-2:0], ge};
        ov[s] <= ov[s-1];
        ng[s] <= ng[s-1];
      end
    end
  end

  assign mag     = q[QW];
  assign ovf     = ov[QW];
  assign neg_out = ng[QW];

endmodule
`default_nettype wire

/* hdl/triangle_transform_and_cull_top.sv */
`default_nettype none
// Channel  Dir  Handshake          Payload
// s_*      in   s_tvalid/s_tready  s_tdata: one triangle, nine Q16.16 coordinates
// m_*      out  m_tvalid/m_tready  m_tdata: nine Q16.16 screen values; m_tuser: flags
// cfg_*    in   cfg_valid/cfg_ready cfg_index, cfg_data: matrix rows and window size
//
// One triangle per cycle unless a stall on m_tready holds the pipe: three stages of
// transform and plane test, 35 stages of the bit-per-stage divider, two of
// viewport mapping and saturation. The divider depth sets the latency.
// Reset (rst, synchronous) empties the pipeline and loads the identity matrix
// and a 640 x 480 window. A stall on m_tready freezes every stage together.
module triangle_transform_and_cull_top (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z (32 bits each)
  input  wire logic [287:0] s_tdata,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // s0_x, s0_y, s0_depth, s1_x, s1_y, s1_depth, s2_x, s2_y, s2_depth (32 bits each)
  output logic      [287:0] m_tdata,
  // culled, w_zero
  output logic      [1:0]   m_tuser,
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [2:0]   cfg_index,
  input  wire logic [63:0]  cfg_data
);

  localparam int CW = ttc_pkg::CLIP_W;
  localparam int QW = ttc_pkg::QUO_W;
  localparam int DS = ttc_pkg::DIV_STAGES;

  // configuration registers
  logic [63:0] mvp [0:3];
  logic [12:0] win_w;
  logic [12:0] win_h;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mvp[0] <= ttc_pkg::ROW0_RESET;
      mvp[1] <= ttc_pkg::ROW1_RESET;
      mvp[2] <= ttc_pkg::ROW2_RESET;
      mvp[3] <= ttc_pkg::ROW3_RESET;
      win_w  <= ttc_pkg::WIDTH_RESET;
      win_h  <= ttc_pkg::HEIGHT_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        ttc_pkg::REG_ROW0:   mvp[0] <= cfg_data;
        ttc_pkg::REG_ROW1:   mvp[1] <= cfg_data;
        ttc_pkg::REG_ROW2:   mvp[2] <= cfg_data;
        ttc_pkg::REG_ROW3:   mvp[3] <= cfg_data;
        ttc_pkg::REG_WIDTH:  win_w  <= cfg_data[12:0];
        ttc_pkg::REG_HEIGHT: win_h  <= cfg_data[12:0];
        default: ;
      endcase
    end
  end

  // advance the whole pipe unless the output holds an untaken request
  logic en;
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  // stage 1: products of matrix entries and coordinates
  logic [47:0] prod [0:2][0:3][0:2];
  logic        v1;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int v = 0; v < 3; v++) begin
        for (int r = 0; r < 4; r++) begin
          for (int c = 0; c < 3; c++) begin
            prod[v][r][c] <= {{32{mvp[r][16*c+15]}}, mvp[r][16*c +: 16]} *
                             {{16{s_tdata[96*v+32*c+31]}}, s_tdata[96*v+32*c +: 32]};
          end
        end
      end
    end
  end

  // stage 2: clip coordinates, the fourth column scaled by w = 1.0
  logic [CW-1:0] clip [0:2][0:3];
  logic          v2;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int v = 0; v < 3; v++) begin
        for (int r = 0; r < 4; r++) begin
          clip[v][r] <= {{2{prod[v][r][0][47]}}, prod[v][r][0]} +
                        {{2{prod[v][r][1][47]}}, prod[v][r][1]} +
                        {{2{prod[v][r][2][47]}}, prod[v][r][2]} +
                        {{18{mvp[r][63]}}, mvp[r][63:48], 16'b0};
        end
      end
    end
  end

  // stage 3: plane tests and magnitudes for the divider
  logic [2:0]    lt   [0:2];
  logic [2:0]    gt   [0:2];
  logic [CW-1:0] cmag [0:2][0:2];
  logic [2:0]    csgn [0:2];
  logic [CW-1:0] wmag [0:2];
  logic [2:0]    wsgn;
  logic [2:0]    wz3;
  logic          v3;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int v = 0; v < 3; v++) begin
        for (int r = 0; r < 3; r++) begin
          lt[v][r] <= $signed({clip[v][r][CW-1], clip[v][r]}) <
                      -$signed({clip[v][3][CW-1], clip[v][3]});
          gt[v][r] <= $signed(clip[v][r]) > $signed(clip[v][3]);
          cmag[v][r] <= clip[v][r][CW-1] ? -clip[v][r] : clip[v][r];
          csgn[v][r] <= clip[v][r][CW-1];
        end
        wmag[v] <= clip[v][3][CW-1] ? -clip[v][3] : clip[v][3];
        wsgn[v] <= clip[v][3][CW-1];
        wz3[v]  <= (clip[v][3] == '0);
      end
    end
  end

  // drop the triangle when every vertex lies outside an x or y plane and all lie beyond one common plane
  logic [2:0] outside;
  logic       cull3;

  always_comb begin
    for (int v = 0; v < 3; v++) begin
      outside[v] = lt[v][0] | gt[v][0] | lt[v][1] | gt[v][1];
    end
    cull3 = (&outside) &&
            ((lt[0][0] & lt[1][0] & lt[2][0]) || (gt[0][0] & gt[1][0] & gt[2][0]) ||
             (lt[0][1] & lt[1][1] & lt[2][1]) || (gt[0][1] & gt[1][1] & gt[2][1]) ||
             (lt[0][2] & lt[1][2] & lt[2][2]) || (gt[0][2] & gt[1][2] & gt[2][2]));
  end

  // dividers: one per x, y and z clip component of each vertex
  logic [QW-1:0] qmag [0:2][0:2];
  logic          qovf [0:2][0:2];
  logic          qneg [0:2][0:2];

  for (genvar gv = 0; gv < 3; gv++) begin : g_vert
    for (genvar gc = 0; gc < 3; gc++) begin : g_comp
      ttc_div u_div (
        .clk     (clk),
        .en      (en),
        .num     (cmag[gv][gc]),
        .den     (wmag[gv]),
        .neg_in  (csgn[gv][gc] ^ wsgn[gv]),
        .mag     (qmag[gv][gc]),
        .ovf     (qovf[gv][gc]),
        .neg_out (qneg[gv][gc])
      );
    end
  end

  // flags travel beside the divider
  logic       sb_vld  [0:DS-1];
  logic       sb_cull [0:DS-1];
  logic [2:0] sb_wz   [0:DS-1];

  always_ff @(posedge clk) begin
    if (en) begin
      sb_cull[0] <= cull3;
      sb_wz[0]   <= wz3;
      for (int k = 1; k < DS; k++) begin
        sb_cull[k] <= sb_cull[k-1];
        sb_wz[k]   <= sb_wz[k-1];
      end
    end
  end

  // stage A: signed NDC and scaled screen products
  logic [QW:0]   ndc  [0:2][0:2];
  logic          aovf [0:2][0:2];
  logic          aneg [0:2][0:2];
  logic          a_cull;
  logic [2:0]    a_wz;
  logic          va;

  always_comb begin
    for (int v = 0; v < 3; v++) begin
      for (int c = 0; c < 3; c++) begin
        ndc[v][c] = qneg[v][c] ? -{1'b0, qmag[v][c]} : {1'b0, qmag[v][c]};
      end
    end
  end

  logic [QW:0] a_ndz [0:2];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int v = 0; v < 3; v++) begin
        for (int c = 0; c < 3; c++) begin
          aovf[v][c] <= qovf[v][c];
          aneg[v][c] <= qneg[v][c];
        end
        a_ndz[v] <= ndc[v][2];
      end
      a_cull <= sb_cull[DS-1];
      a_wz   <= sb_wz[DS-1];
    end
  end

  // screen product (ndc + 1.0) * size, worked for x and y
  logic [QW+1:0] one_x [0:2];
  logic [QW+1:0] one_y [0:2];
  logic [CW-1:0] tx    [0:2];
  logic [CW-1:0] ty    [0:2];

  always_comb begin
    for (int v = 0; v < 3; v++) begin
      one_x[v] = {ndc[v][0][QW], ndc[v][0]} + (QW+2)'(65536);
      one_y[v] = {ndc[v][1][QW], ndc[v][1]} + (QW+2)'(65536);
      tx[v] = {{(CW-QW-2){one_x[v][QW+1]}}, one_x[v]} * {{(CW-13){1'b0}}, win_w};
      ty[v] = {{(CW-QW-2){one_y[v][QW+1]}}, one_y[v]} * {{(CW-13){1'b0}}, win_h};
    end
  end

  logic [CW-1:0] a_tx [0:2];
  logic [CW-1:0] a_ty [0:2];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int v = 0; v < 3; v++) begin
        a_tx[v] <= tx[v];
        a_ty[v] <= ty[v];
      end
    end
  end

  function automatic logic [31:0] sat32(input logic [CW-1:0] h);
    logic [31:0] res;
    if (!h[CW-1] && (|h[CW-2:31])) begin
      res = 32'h7FFF_FFFF;
    end else if (h[CW-1] && !(&h[CW-2:31])) begin
      res = 32'h8000_0000;
    end else begin
      res = h[31:0];
    end
    return res;
  endfunction

  // halve toward zero
  function automatic logic [CW-1:0] half(input logic [CW-1:0] t);
    logic [CW-1:0] h;
    h = t + {{(CW-1){1'b0}}, t[CW-1]};
    return {h[CW-1], h[CW-1:1]};
  endfunction

  // stage B: saturate, mask culled and zero-w vertices, hold in output register
  logic [31:0] fx [0:2];
  logic [31:0] fy [0:2];
  logic [31:0] fz [0:2];

  always_comb begin
    for (int v = 0; v < 3; v++) begin
      if (aovf[v][0]) begin
        fx[v] = (win_w == '0) ? 32'h0 : (aneg[v][0] ? 32'h8000_0000 : 32'h7FFF_FFFF);
      end else begin
        fx[v] = sat32(half(a_tx[v]));
      end
      if (aovf[v][1]) begin
        fy[v] = (win_h == '0) ? 32'h0 : (aneg[v][1] ? 32'h8000_0000 : 32'h7FFF_FFFF);
      end else begin
        fy[v] = sat32(half(a_ty[v]));
      end
      if (aovf[v][2]) begin
        fz[v] = aneg[v][2] ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end else begin
        fz[v] = sat32({{(CW-QW-1){a_ndz[v][QW]}}, a_ndz[v]});
      end
      if (a_cull || a_wz[v]) begin
        fx[v] = '0;
        fy[v] = '0;
        fz[v] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int v = 0; v < 3; v++) begin
        m_tdata[96*v +: 32]    <= fx[v];
        m_tdata[96*v+32 +: 32] <= fy[v];
        m_tdata[96*v+64 +: 32] <= fz[v];
      end
      m_tuser[0] <= a_cull;
      m_tuser[1] <= !a_cull && (|a_wz);
    end
  end

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      v1       <= 1'b0;
      v2       <= 1'b0;
      v3       <= 1'b0;
      va       <= 1'b0;
      m_tvalid <= 1'b0;
      for (int k = 0; k < DS; k++) begin
        sb_vld[k] <= 1'b0;
      end
    end else if (en) begin
      v1        <= s_tvalid;
      v2        <= v1;
      v3        <= v2;
      sb_vld[0] <= v3;
      for (int k = 1; k < DS; k++) begin
        sb_vld[k] <= sb_vld[k-1];
      end
      va       <= sb_vld[DS-1];
      m_tvalid <= va;
    end
  end

endmodule
`default_nettype wire

/* tb/sv/tb.sv */
module tb;

  localparam int LATENCY   = 40;
  localparam int WDOG_MAX  = 20000;
  localparam longint ONE   = 65536;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [287:0] s_tdata = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [287:0] m_tdata;
  logic [1:0]   m_tuser;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [2:0]   cfg_index = ttc_pkg::REG_ROW0;
  logic [63:0]  cfg_data = '0;

  // shadow of the block's registers, updated on each accepted write
  logic [63:0] mvp_rows[4] = '{ttc_pkg::ROW0_RESET, ttc_pkg::ROW1_RESET,
                               ttc_pkg::ROW2_RESET, ttc_pkg::ROW3_RESET};
  logic [12:0] win_w = ttc_pkg::WIDTH_RESET;
  logic [12:0] win_h = ttc_pkg::HEIGHT_RESET;

  // {w_zero, culled, nine screen fields} per accepted triangle
  logic [289:0] screen_q[$];
  int err_count = 0;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int rx_hold_left = 0;
  int stall_cnt = 0;

  triangle_transform_and_cull_top u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Triangle predictor
  // ---------------------------------------------------------------------
  function automatic longint row_dot(logic [63:0] row, longint v[4]);
    longint acc;
    acc = 0;
    for (int c = 0; c < 4; c++) acc += longint'($signed(row[16*c +: 16])) * v[c];
    return acc;
  endfunction

  // Q16.16 quotient, magnitude truncated, sign applied afterwards
  function automatic longint q16_div(longint a, longint b);
    logic neg;
    longint unsigned ua, ub, qi, r, fr, mag;
    neg = (a < 0) != (b < 0);
    ua = (a < 0) ? longint'(-a) : a;
    ub = (b < 0) ? longint'(-b) : b;
    qi = ua / ub;
    r  = ua % ub;
    fr = 0;
    for (int i = 0; i < 16; i++) begin
      r  = r << 1;
      fr = fr << 1;
      if (r >= ub) begin
        r  = r - ub;
        fr = fr | 1;
      end
    end
    if (qi > 64'h1_0000_0000) qi = 64'h1_0000_0000;
    mag = (qi << 16) | fr;
    return neg ? -longint'(mag) : longint'(mag);
  endfunction

  function automatic logic [31:0] sat32(longint v);
    if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'h8000_0000;
    return v[31:0];
  endfunction

  function automatic longint to_screen(longint ndc, logic [12:0] size);
    longint t;
    t = (ndc + ONE) * longint'({51'b0, size});
    return t / 2;
  endfunction

  function automatic logic [289:0] predict_screen(logic [287:0] tri_in);
    longint cx[3], cy[3], cz[3], cw[3];
    longint v[4];
    logic   outs[3];
    logic   cull, wz;
    logic [287:0] res;
    wz  = 1'b0;
    res = '0;
    for (int i = 0; i < 3; i++) begin
      for (int k = 0; k < 3; k++) v[k] = longint'($signed(tri_in[96*i + 32*k +: 32]));
      v[3] = ONE;
      cx[i] = row_dot(mvp_rows[0], v);
      cy[i] = row_dot(mvp_rows[1], v);
      cz[i] = row_dot(mvp_rows[2], v);
      cw[i] = row_dot(mvp_rows[3], v);
      outs[i] = cx[i] < -cw[i] || cx[i] > cw[i] || cy[i] < -cw[i] || cy[i] > cw[i];
    end
    cull = outs[0] && outs[1] && outs[2] && (
      (cx[0] < -cw[0] && cx[1] < -cw[1] && cx[2] < -cw[2]) ||
      (cx[0] >  cw[0] && cx[1] >  cw[1] && cx[2] >  cw[2]) ||
      (cy[0] < -cw[0] && cy[1] < -cw[1] && cy[2] < -cw[2]) ||
      (cy[0] >  cw[0] && cy[1] >  cw[1] && cy[2] >  cw[2]) ||
      (cz[0] < -cw[0] && cz[1] < -cw[1] && cz[2] < -cw[2]) ||
      (cz[0] >  cw[0] && cz[1] >  cw[1] && cz[2] >  cw[2]));
    if (!cull) begin
      for (int i = 0; i < 3; i++) begin
        if (cw[i] == 0) begin
          wz = 1'b1;
        end else begin
          res[96*i      +: 32] = sat32(to_screen(q16_div(cx[i], cw[i]), win_w));
          res[96*i + 32 +: 32] = sat32(to_screen(q16_div(cy[i], cw[i]), win_h));
          res[96*i + 64 +: 32] = sat32(q16_div(cz[i], cw[i]));
        end
      end
    end
    return {wz, cull, res};
  endfunction

  // ---------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------
  task automatic report(string what, int field, logic [31:0] got, logic [31:0] want);
    $display("%0t mismatch %s field %0d: got %h want %h", $realtime, what, field, got, want);
    err_count++;
  endtask

  // write one register (the caller keeps the block idle; the task does not check), then idle the channel
  task automatic cfg_write(logic [2:0] idx, logic [63:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      ttc_pkg::REG_ROW0:   mvp_rows[0] = val;
      ttc_pkg::REG_ROW1:   mvp_rows[1] = val;
      ttc_pkg::REG_ROW2:   mvp_rows[2] = val;
      ttc_pkg::REG_ROW3:   mvp_rows[3] = val;
      ttc_pkg::REG_WIDTH:  win_w = val[12:0];
      ttc_pkg::REG_HEIGHT: win_h = val[12:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic load_matrix(logic [63:0] r0, r1, r2, r3);
    cfg_write(ttc_pkg::REG_ROW0, r0);
    cfg_write(ttc_pkg::REG_ROW1, r1);
    cfg_write(ttc_pkg::REG_ROW2, r2);
    cfg_write(ttc_pkg::REG_ROW3, r3);
  endtask

  // send one triangle; valid stays high into the next request when no gap is drawn
  task automatic send_tri(logic [287:0] tri_in);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= tri_in;
    do @(posedge clk); while (!s_tready);
    screen_q = {screen_q, predict_screen(tri_in)};
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (screen_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  function automatic logic [287:0] tri9(int a, b, c, d, e, f, g, h, i);
    return {i, h, g, f, e, d, c, b, a};
  endfunction

  function automatic logic [31:0] rand_coord();
    // mostly near the unit cube, sometimes any 32-bit value
    if ($urandom_range(4) == 0) return $urandom;
    return $urandom_range(6 * 65536) - 3 * 65536;
  endfunction

  function automatic logic [287:0] rand_tri();
    logic [287:0] t;
    for (int k = 0; k < 9; k++) t[32*k +: 32] = rand_coord();
    return t;
  endfunction

  function automatic logic [63:0] rand_row(int diag);
    logic [63:0] row;
    for (int c = 0; c < 4; c++) begin
      if ($urandom_range(7) == 0) row[16*c +: 16] = 16'($urandom);
      else row[16*c +: 16] = 16'($urandom_range(768) - 384 + ((c == diag) ? 256 : 0));
    end
    return row;
  endfunction

  task automatic load_random_config();
    load_matrix(rand_row(0), rand_row(1), rand_row(2), rand_row(3));
    cfg_write(ttc_pkg::REG_WIDTH,  64'($urandom_range(4096, 1)));
    cfg_write(ttc_pkg::REG_HEIGHT, 64'($urandom_range(4096, 1)));
  endtask

  // ---------------------------------------------------------------------
  // Receiver, checker, watchdog
  // ---------------------------------------------------------------------
  // hold off for a long stretch on request, else stall at the set rate
  always @(posedge clk) begin
    if (rx_hold_left > 0) begin
      m_tready <= 1'b0;
      rx_hold_left <= rx_hold_left - 1;
    end else begin
      m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // compare each result with the oldest prediction, field by field
  always @(posedge clk) begin
    logic [289:0] want;
    if (!rst && m_tvalid && m_tready) begin
      if (screen_q.size() == 0) begin
        report("unexpected result", 0, m_tdata[31:0], 32'h0);
      end else begin
        want = screen_q.pop_front();
        for (int k = 0; k < 9; k++)
          if (m_tdata[32*k +: 32] !== want[32*k +: 32])
            report("screen", k, m_tdata[32*k +: 32], want[32*k +: 32]);
        if (m_tuser[0] !== want[288])
          report("culled", 0, 32'(m_tuser[0]), 32'(want[288]));
        if (m_tuser[1] !== want[289])
          report("w_zero", 0, 32'(m_tuser[1]), 32'(want[289]));
      end
    end
  end

  // end the run when nothing moves on any channel for too long
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      stall_cnt <= 0;
    else
      stall_cnt <= stall_cnt + 1;
    if (stall_cnt == WDOG_MAX) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------
  // field extremes and every cull plane under the reset matrix
  task automatic test_planes();
    send_tri('0);
    send_tri({9{32'h7FFF_FFFF}});
    send_tri({9{32'h8000_0000}});
    send_tri({3{32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF}});
    send_tri(tri9(-131072, 0, 0, -196608, 1000, 0, -70000, -5, 9));          // x < -w
    send_tri(tri9(131072, 0, 0, 196608, 1000, 0, 70000, -5, 9));             // x > w
    send_tri(tri9(0, -131072, 0, 100, -99999, 0, 5, -70000, 0));             // y < -w
    send_tri(tri9(0, 131072, 0, 100, 99999, 0, 5, 70000, 0));                // y > w
    send_tri(tri9(131072, 0, -131072, -131072, 0, -200000, 131072, 0, -70000)); // z < -w
    send_tri(tri9(131072, 0, 131072, -131072, 0, 200000, 131072, 0, 70000)); // z > w
    // all outside but on different planes: kept
    send_tri(tri9(131072, 0, 0, -131072, 0, 0, 0, 131072, 0));
    // exactly on the planes: inside
    send_tri(tri9(65536, 65536, 65536, -65536, -65536, -65536, 32768, -32768, 0));
    drain();
  endtask

  // w equal to zero on all vertices, then on a single vertex
  task automatic test_zero_w();
    cfg_write(ttc_pkg::REG_ROW3, 64'h0);
    send_tri(tri9(1, 2, 3, 4, 5, 6, 7, 8, 9));
    drain();
    cfg_write(ttc_pkg::REG_ROW3, 64'h0000_0000_0000_0100);   // w = x
    send_tri(tri9(0, 0, 0, 65536, 30000, -30000, 40000, 20000, 10000));
    send_tri(tri9(-65536, 0, 0, 0, 5, 5, 65536, 100, 100));
    drain();
    load_matrix(ttc_pkg::ROW0_RESET, ttc_pkg::ROW1_RESET,
                ttc_pkg::ROW2_RESET, ttc_pkg::ROW3_RESET);
  endtask

  // saturating matrices and window sizes at and beyond their range
  task automatic test_extreme_config();
    load_matrix({4{16'h7FFF}}, {4{16'h8000}}, {4{16'h7FFF}}, 64'h0001_0000_0000_0001);
    cfg_write(ttc_pkg::REG_WIDTH, 64'd1);
    cfg_write(ttc_pkg::REG_HEIGHT, 64'd4096);
    send_tri({9{32'h7FFF_FFFF}});
    send_tri({9{32'h8000_0000}});
    send_tri(tri9(1, -1, 65536, -65536, 3, 0, 2, 2, 2));
    drain();
    load_matrix(ttc_pkg::ROW0_RESET, ttc_pkg::ROW1_RESET,
                ttc_pkg::ROW2_RESET, {4{16'hFFFF}});
    cfg_write(ttc_pkg::REG_WIDTH, 64'h0);
    cfg_write(ttc_pkg::REG_HEIGHT, 64'hFFFF_FFFF_FFFF_FFFF);  // masked to 13 bits
    send_tri(tri9(1000, -1000, 500, 65536, 0, 0, -32768, 32768, 7));
    send_tri(tri9(0, 0, 0, 20000, 20000, 20000, -20000, -20000, -20000));
    drain();
    cfg_write(ttc_pkg::REG_WIDTH, 64'd4096);
    cfg_write(ttc_pkg::REG_HEIGHT, 64'd1);
    send_tri(tri9(0, 0, 0, 20000, 20000, 20000, -20000, -20000, -20000));
    drain();
  endtask

  task automatic test_random(int n, int tx_pct, int rx_pct);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    for (int blk = 0; blk < n / 25; blk++) begin
      load_random_config();
      repeat (25) send_tri(rand_tri());
      drain();
    end
  endtask

  // stop the receiver long enough to fill the pipe and stall the input
  task automatic test_backpressure();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    load_random_config();
    rx_hold_left = 300;
    repeat (60) send_tri(rand_tri());
    drain();
  endtask

  // pause the sender until every pending result is back, then resume
  task automatic test_pause_refill();
    tx_idle_pct = 10;
    rx_idle_pct = 20;
    repeat (3) begin
      repeat (8) send_tri(rand_tri());
      s_tvalid <= 1'b0;
      while (screen_q.size() != 0) @(posedge clk);
    end
    drain();
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_planes();
    test_zero_w();
    test_extreme_config();
    test_random(150, 8, 54);
    test_random(150, 54, 8);
    test_random(75, 0, 0);
    test_backpressure();
    test_pause_refill();
    if (err_count == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
